// File: hw/rtl/set_symmetric_difference_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set symmetric difference unit
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SET_SYMMETRIC_DIFFERENCE_UNIT_ASSERT_SVH
`define SET_SYMMETRIC_DIFFERENCE_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SSDU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssdu assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define SSDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssdu assertion failed");

`endif

// File: hw/rtl/ssdu_pkg.sv
// ----------------------------------------------------------------------------
// Set symmetric difference unit package
// Operation codes, data width and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdu_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_EMIT   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_a;       // append the input value to set A
        logic wr_b;       // append the input value to set B
        logic lat_cand;   // capture the candidate from the read data
        logic clr_hit;    // start a new match search
        logic cmp_self;   // read data of the candidate's own set is in range
        logic cmp_other;  // read data of the other set is in range
        logic cand_b;     // candidates currently come from set B
        logic push;       // candidate is a result: move it into the pending slot
        logic finish;     // release the pending result as the last beat
        logic clr_cnt;    // both sets become empty
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;        // candidate matched an earlier own element or the other set
        logic pend_valid; // a result waits in the pending slot
        logic out_free;   // the output register can take a beat this cycle
    } t_stat;

endpackage

`default_nettype wire

// File: hw/rtl/ssdu_datapath.sv
// ----------------------------------------------------------------------------
// Set symmetric difference datapath
// Set memories, element counts, candidate compare, pending slot and output.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdu_datapath #(
    parameter int MAX_ELEMS = 32,
    localparam int CNT_W = $clog2(MAX_ELEMS + 1),
    localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire ssdu_pkg::t_cmd              i_cmd,
    input  wire [IDX_W-1:0]                  i_rd_idx,
    input  wire [ssdu_pkg::DATA_W-1:0]       i_value,
    input  wire                              i_out_ready,
    output ssdu_pkg::t_stat                  o_stat,
    output logic [CNT_W-1:0]                 o_cnt_a,
    output logic [CNT_W-1:0]                 o_cnt_b,
    output logic                             o_out_valid,
    output logic [ssdu_pkg::DATA_W-1:0]      o_out_value,
    output logic                             o_out_last,
    output logic                             o_out_none
);

    logic [ssdu_pkg::DATA_W-1:0] mem_a [MAX_ELEMS];
    logic [ssdu_pkg::DATA_W-1:0] mem_b [MAX_ELEMS];

    logic [CNT_W-1:0]            r_cnt_a;
    logic [CNT_W-1:0]            r_cnt_b;
    logic [ssdu_pkg::DATA_W-1:0] r_rd_a;
    logic [ssdu_pkg::DATA_W-1:0] r_rd_b;
    logic [ssdu_pkg::DATA_W-1:0] r_cand;
    logic                        r_hit;
    logic                        r_pend_valid;
    logic [ssdu_pkg::DATA_W-1:0] r_pend_value;
    logic                        r_out_valid;
    logic [ssdu_pkg::DATA_W-1:0] r_out_value;
    logic                        r_out_last;
    logic                        r_out_none;

    logic                        full_a;
    logic                        full_b;
    logic [ssdu_pkg::DATA_W-1:0] self_data;
    logic [ssdu_pkg::DATA_W-1:0] other_data;
    logic                        match;

    assign full_a     = (r_cnt_a == CNT_W'(MAX_ELEMS));
    assign full_b     = (r_cnt_b == CNT_W'(MAX_ELEMS));
    assign self_data  = i_cmd.cand_b ? r_rd_b : r_rd_a;
    assign other_data = i_cmd.cand_b ? r_rd_a : r_rd_b;
    assign match      = (i_cmd.cmp_self  && (self_data  == r_cand)) ||
                        (i_cmd.cmp_other && (other_data == r_cand));

    // Set memories: one write port on load, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && !full_a) begin
            mem_a[r_cnt_a[IDX_W-1:0]] <= i_value;
        end
        if (i_cmd.wr_b && !full_b) begin
            mem_b[r_cnt_b[IDX_W-1:0]] <= i_value;
        end
        r_rd_a <= mem_a[i_rd_idx];
        r_rd_b <= mem_b[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_cand) begin
            r_cand <= i_cmd.cand_b ? r_rd_b : r_rd_a;
        end
        if (i_cmd.push) begin
            r_pend_value <= r_cand;
        end
        if (i_cmd.push && r_pend_valid) begin
            r_out_value <= r_pend_value;
        end else if (i_cmd.finish) begin
            r_out_value <= r_pend_valid ? r_pend_value : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_hit        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
            r_out_none   <= 1'b0;
        end else begin
            if (i_cmd.clr_cnt) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
            end else begin
                if (i_cmd.wr_a && !full_a) begin
                    r_cnt_a <= r_cnt_a + CNT_W'(1);
                end
                if (i_cmd.wr_b && !full_b) begin
                    r_cnt_b <= r_cnt_b + CNT_W'(1);
                end
            end

            if (i_cmd.clr_hit) begin
                r_hit <= 1'b0;
            end else if (match) begin
                r_hit <= 1'b1;
            end

            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end

            if (i_cmd.push && r_pend_valid) begin
                r_out_valid <= 1'b1;
                r_out_last  <= 1'b0;
                r_out_none  <= 1'b0;
            end else if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_out_last  <= 1'b1;
                r_out_none  <= !r_pend_valid;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.hit        = r_hit;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_cnt_a     = r_cnt_a;
    assign o_cnt_b     = r_cnt_b;
    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;
    assign o_out_none  = r_out_none;

endmodule

`default_nettype wire

// File: hw/rtl/ssdu_ctrl.sv
// ----------------------------------------------------------------------------
// Set symmetric difference controller
// Accepts items and sequences the candidate scan over both set memories.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdu_ctrl #(
    parameter int MAX_ELEMS = 32,
    localparam int CNT_W = $clog2(MAX_ELEMS + 1),
    localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire ssdu_pkg::t_op    i_op,
    output logic                  o_in_ready,
    input  wire ssdu_pkg::t_stat  i_stat,
    input  wire [CNT_W-1:0]       i_cnt_a,
    input  wire [CNT_W-1:0]       i_cnt_b,
    output ssdu_pkg::t_cmd        o_cmd,
    output logic [IDX_W-1:0]      o_rd_idx
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_CAND,
        S_SCAN,
        S_DECIDE,
        S_FINISH
    } t_state;

    t_state           r_state;
    logic             r_phase_b;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic             r_cmp_self;
    logic             r_cmp_other;

    logic             accept;
    logic [CNT_W-1:0] own_cnt;
    logic [CNT_W-1:0] other_cnt;
    logic [CNT_W-1:0] scan_len;
    logic             push_ok;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign own_cnt    = r_phase_b ? i_cnt_b : i_cnt_a;
    assign other_cnt  = r_phase_b ? i_cnt_a : i_cnt_b;
    assign scan_len   = (r_i > other_cnt) ? r_i : other_cnt;
    assign push_ok    = !i_stat.pend_valid || i_stat.out_free;
    assign o_rd_idx   = (r_state == S_NEXT) ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0];

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_a      = accept && (i_op == ssdu_pkg::OP_LOAD_A);
        o_cmd.wr_b      = accept && (i_op == ssdu_pkg::OP_LOAD_B);
        o_cmd.lat_cand  = (r_state == S_CAND);
        o_cmd.clr_hit   = (r_state == S_CAND);
        o_cmd.cmp_self  = r_cmp_self;
        o_cmd.cmp_other = r_cmp_other;
        o_cmd.cand_b    = r_phase_b;
        o_cmd.push      = (r_state == S_DECIDE) && !i_stat.hit && push_ok;
        o_cmd.finish    = (r_state == S_FINISH) && i_stat.out_free;
        o_cmd.clr_cnt   = o_cmd.finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase_b   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_cmp_self  <= 1'b0;
            r_cmp_other <= 1'b0;
        end else begin
            r_cmp_self  <= 1'b0;
            r_cmp_other <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_op == ssdu_pkg::OP_EMIT)) begin
                        r_phase_b <= 1'b0;
                        r_i       <= '0;
                        r_state   <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_i == own_cnt) begin
                        if (r_phase_b) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_phase_b <= 1'b1;
                            r_i       <= '0;
                        end
                    end else begin
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    r_j     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_j == scan_len) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_cmp_self  <= (r_j < r_i);
                        r_cmp_other <= (r_j < other_cnt);
                        r_j         <= r_j + CNT_W'(1);
                    end
                end
                S_DECIDE: begin
                    if (i_stat.hit || push_ok) begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_NEXT;
                    end
                end
                S_FINISH: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/set_symmetric_difference_unit.sv
// ----------------------------------------------------------------------------
// Set symmetric difference unit
// Loads two sets of 32-bit values and streams their symmetric difference.
// ----------------------------------------------------------------------------
// Load beats (operation 0 for set A, 1 for set B) are taken one per cycle
// while the unit is idle; each set keeps up to MAX_ELEMS values in load order
// and further loads into a full set are dropped without a result. An emit
// beat (operation 2) starts a scan that takes every element of A, then every
// element of B, as a candidate, and compares it against the earlier elements
// of its own set and all elements of the other set, one pair of compares per
// cycle through the single read port of each set memory. Input ready stays
// low for the whole run. Results leave through an output register, with the
// last beat flagged; an empty difference yields one beat with none_found set
// and a zero value. Both sets are empty again after the run. Operation 3 is
// accepted and ignored. Values compare on all 32 bits, so any bit pattern is
// an element.
// ----------------------------------------------------------------------------
`default_nettype none

module set_symmetric_difference_unit #(
    parameter int MAX_ELEMS = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [ssdu_pkg::OP_W-1:0]          i_operation,
    input  wire signed [ssdu_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic signed [ssdu_pkg::DATA_W-1:0] o_value_res,
    output logic                              o_is_last,
    output logic                              o_none_found
);

    localparam int CNT_W = $clog2(MAX_ELEMS + 1);
    localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

    // Controller/datapath handshake: commands down, status up.
    ssdu_pkg::t_cmd              cmd;
    ssdu_pkg::t_stat             stat;
    logic [CNT_W-1:0]            cnt_a;
    logic [CNT_W-1:0]            cnt_b;
    logic [IDX_W-1:0]            rd_idx;
    logic [ssdu_pkg::DATA_W-1:0] out_value;

    ssdu_ctrl #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (ssdu_pkg::t_op'(i_operation)),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .i_cnt_a    (cnt_a),
        .i_cnt_b    (cnt_b),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx)
    );

    // The datapath holds the set memories, the counts, the candidate compare
    // and a pending slot that holds each result back until the next one (or
    // the end of the run) shows whether it is the last beat.
    ssdu_datapath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_idx    (rd_idx),
        .i_value     (i_value),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_cnt_a     (cnt_a),
        .o_cnt_b     (cnt_b),
        .o_out_valid (o_out_valid),
        .o_out_value (out_value),
        .o_out_last  (o_is_last),
        .o_out_none  (o_none_found)
    );

    assign o_value_res = out_value;

endmodule

`default_nettype wire

// File: hw/rtl/ssdu_checker.sv
// ----------------------------------------------------------------------------
// Set symmetric difference port checker
// Port-level checks on result beats and run sequencing, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_symmetric_difference_unit_assert.svh"

module ssdu_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_ready,
    input wire [ssdu_pkg::OP_W-1:0]          i_operation,
    input wire                               o_out_valid,
    input wire                               i_out_ready,
    input wire [ssdu_pkg::DATA_W-1:0]        o_value_res,
    input wire                               o_is_last,
    input wire                               o_none_found
);

    // An empty difference is a single, final beat with a zero value.
    `SSDU_ASSERT_NOW(a_none_is_final, i_clk, i_rst_n, o_out_valid && o_none_found, o_is_last && (o_value_res == '0))

    // A beat that is not the last one only appears while a run is in flight.
    `SSDU_ASSERT_NOW(a_mid_run_busy, i_clk, i_rst_n, o_out_valid && !o_is_last, !o_in_ready)

    // Accepting an emit beat starts a run, which blocks the input.
    `SSDU_ASSERT_NEXT(a_emit_starts_run, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_operation == ssdu_pkg::OP_EMIT), !o_in_ready)

    // A stalled result beat holds its payload.
    `SSDU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_value_res) && $stable(o_is_last))

endmodule

bind set_symmetric_difference_unit ssdu_checker u_ssdu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_operation  (i_operation),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_value_res  (o_value_res),
    .o_is_last    (o_is_last),
    .o_none_found (o_none_found)
);

`default_nettype wire
